// ===== src/stunma_pkg.sv =====
// shared constants for the stun mapped address parser
package stunma_pkg;

	localparam int unsigned HEADER_BYTES = 20;

	localparam logic [15:0] MAPPED_KIND   = 16'h0001;
	localparam logic [15:0] MIN_VALUE_LEN = 16'd8;
	localparam logic [7:0]  FAMILY_IPV4   = 8'd1;

	localparam logic [1:0] PHASE_HEADER  = 2'd0;
	localparam logic [1:0] PHASE_ATTR    = 2'd1;
	localparam logic [1:0] PHASE_MATCHED = 2'd2;

	localparam logic [1:0] STATUS_FOUND   = 2'd0;
	localparam logic [1:0] STATUS_SHORT   = 2'd1;
	localparam logic [1:0] STATUS_MISSING = 2'd2;

	typedef logic [16:0] attr_offset_t;

endpackage

// ===== src/stun_mapped_address_parser.sv =====
// STUN response byte parser: walks attributes and reports the mapped IPv4 address and port
//
// Takes one packet byte per clock cycle. The 20-byte header is skipped, then each
// attribute is tracked by a running byte offset, so every byte is handled as it arrives
// and a new byte can follow in the next cycle. On the byte marked last, one result
// transaction (status, port, address) is loaded into the output register and shows on the
// outputs in the next cycle; the parser state returns to its reset values and the next
// byte starts a new packet. The input is stalled only while a result is held and the
// output side stalls it.
module stun_mapped_address_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] reflex_port,
	output logic [31:0] mapped_addr
);

	logic [4:0]                   header_count_q;
	logic [1:0]                   phase_q;
	logic [15:0]                  attr_kind_q;
	logic [15:0]                  attr_length_q;
	stunma_pkg::attr_offset_t     attr_offset_q;
	logic                         family_ok_q;
	logic                         match_found_q;
	logic [15:0]                  held_port_q;
	logic [31:0]                  held_addr_q;

	logic                         out_valid_q;
	logic [1:0]                   status_q;
	logic [15:0]                  port_q;
	logic [31:0]                  addr_q;

	logic                         accept;
	logic [4:0]                   header_count_d;
	logic [1:0]                   phase_d;
	logic [15:0]                  attr_kind_d;
	logic [15:0]                  attr_length_d;
	stunma_pkg::attr_offset_t     attr_offset_d;
	logic                         family_ok_d;
	logic                         match_found_d;
	logic [15:0]                  held_port_d;
	logic [31:0]                  held_addr_d;
	logic [17:0]                  offset_inc;
	logic [17:0]                  value_end;
	logic [17:0]                  padded_end;
	logic [1:0]                   status_d;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		header_count_d = header_count_q;
		phase_d        = phase_q;
		attr_kind_d    = attr_kind_q;
		attr_length_d  = attr_length_q;
		attr_offset_d  = attr_offset_q;
		family_ok_d    = family_ok_q;
		match_found_d  = match_found_q;
		held_port_d    = held_port_q;
		held_addr_d    = held_addr_q;
		offset_inc     = {1'b0, attr_offset_q} + 18'd1;
		value_end      = 18'd0;
		padded_end     = 18'd0;

		case (phase_q)
			stunma_pkg::PHASE_HEADER: begin
				header_count_d = header_count_q + 5'd1;
				if (header_count_d >= 5'(stunma_pkg::HEADER_BYTES)) begin
					phase_d       = stunma_pkg::PHASE_ATTR;
					attr_offset_d = '0;
				end
			end
			stunma_pkg::PHASE_ATTR: begin
				case (attr_offset_q)
					17'd0: begin
						attr_kind_d = {data_byte, 8'h00};
						family_ok_d = 1'b0;
					end
					17'd1:  attr_kind_d   = {attr_kind_q[15:8], data_byte};
					17'd2:  attr_length_d = {data_byte, 8'h00};
					17'd3:  attr_length_d = {attr_length_q[15:8], data_byte};
					17'd5:  family_ok_d   = (data_byte == stunma_pkg::FAMILY_IPV4);
					17'd6:  held_port_d   = {data_byte, held_port_q[7:0]};
					17'd7:  held_port_d   = {held_port_q[15:8], data_byte};
					17'd8:  held_addr_d   = {data_byte, held_addr_q[23:0]};
					17'd9:  held_addr_d   = {held_addr_q[31:24], data_byte, held_addr_q[15:0]};
					17'd10: held_addr_d   = {held_addr_q[31:16], data_byte, held_addr_q[7:0]};
					17'd11: held_addr_d   = {held_addr_q[31:8], data_byte};
					default: ;
				endcase

				// value end and padded end both count the 4 attribute header bytes
				value_end  = {2'b00, attr_length_d} + 18'd4;
				padded_end = (({2'b00, attr_length_d} + 18'd3) & ~18'd3) + 18'd4;

				if (attr_offset_q >= 17'd4 && attr_kind_d == stunma_pkg::MAPPED_KIND
						&& attr_length_d >= stunma_pkg::MIN_VALUE_LEN && family_ok_d
						&& offset_inc == value_end) begin
					match_found_d = 1'b1;
					phase_d       = stunma_pkg::PHASE_MATCHED;
				end else if (attr_offset_q >= 17'd3 && offset_inc >= padded_end) begin
					attr_offset_d = '0;
				end else begin
					attr_offset_d = offset_inc[16:0];
				end
			end
			default: ;
		endcase

		if (match_found_d) begin
			status_d = stunma_pkg::STATUS_FOUND;
		end else if (phase_d == stunma_pkg::PHASE_HEADER) begin
			status_d = stunma_pkg::STATUS_SHORT;
		end else begin
			status_d = stunma_pkg::STATUS_MISSING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q <= '0;
			phase_q        <= stunma_pkg::PHASE_HEADER;
			attr_kind_q    <= '0;
			attr_length_q  <= '0;
			attr_offset_q  <= '0;
			family_ok_q    <= 1'b0;
			match_found_q  <= 1'b0;
			held_port_q    <= '0;
			held_addr_q    <= '0;
		end else if (accept) begin
			if (last_byte) begin
				// packet done, start over for the next one
				header_count_q <= '0;
				phase_q        <= stunma_pkg::PHASE_HEADER;
				attr_kind_q    <= '0;
				attr_length_q  <= '0;
				attr_offset_q  <= '0;
				family_ok_q    <= 1'b0;
				match_found_q  <= 1'b0;
				held_port_q    <= '0;
				held_addr_q    <= '0;
			end else begin
				header_count_q <= header_count_d;
				phase_q        <= phase_d;
				attr_kind_q    <= attr_kind_d;
				attr_length_q  <= attr_length_d;
				attr_offset_q  <= attr_offset_d;
				family_ok_q    <= family_ok_d;
				match_found_q  <= match_found_d;
				held_port_q    <= held_port_d;
				held_addr_q    <= held_addr_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			status_q <= status_d;
			port_q   <= match_found_d ? held_port_d : 16'h0000;
			addr_q   <= match_found_d ? held_addr_d : 32'h0000_0000;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign reflex_port = port_q;
	assign mapped_addr = addr_q;

`ifndef ASSERT_OFF
	a_match_phase: assert property (@(posedge clk) disable iff (!arst_n)
		match_found_q |-> phase_q == stunma_pkg::PHASE_MATCHED)
		else $error("match flag set outside matched phase");

	a_header_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == stunma_pkg::PHASE_HEADER |-> header_count_q < 5'(stunma_pkg::HEADER_BYTES))
		else $error("header count past header length");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with no result held");

	a_zero_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != stunma_pkg::STATUS_FOUND
			|-> port_q == 16'h0000 && addr_q == 32'h0000_0000)
		else $error("address reported without a match");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> phase_q == stunma_pkg::PHASE_HEADER && header_count_q == 5'd0)
		else $error("parser not restarted after last byte");
`endif

endmodule
